FILE: hdl/cnb_pkg.sv
package cnb_pkg;

  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [7:0] MagicByte = 8'h46;  // 'F'
  localparam logic [7:0] CmdSet    = 8'h53;  // 'S'
  localparam logic [7:0] CmdLoad   = 8'h4C;  // 'L'
  localparam logic [7:0] LoadFlag  = 8'h20;

  localparam logic [8:0]  AddrFlag   = 9'h100;
  localparam logic [11:0] StopBits   = 12'hC00;
  localparam logic [3:0]  WordBits   = 4'd12;
  localparam logic [2:0]  FrameWords = 3'd5;

  // parse positions of the six-byte command
  localparam logic [2:0] PosMagic = 3'd0;
  localparam logic [2:0] PosCmd   = 3'd1;
  localparam logic [2:0] PosAddr  = 3'd2;
  localparam logic [2:0] PosRed   = 3'd3;
  localparam logic [2:0] PosGreen = 3'd4;
  localparam logic [2:0] PosBlue  = 3'd5;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
    logic [3:0] zeros;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [3:0] zero_count(logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, ~v[i]};
    end
    return n;
  endfunction

endpackage

FILE: hdl/cnb_front.sv
module cnb_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [7:0]         rx_byte_i,
  input  cnb_pkg::fifo_stat_t stat_i,
  output logic               push_o,
  output cnb_pkg::op_t       op_o
);
  import cnb_pkg::*;

  assign in_stall_o = stat_i.full;
  assign push_o     = in_valid_i && !stat_i.full;

  // zero-bit count is taken here so the back end only adds
  always_comb begin
    op_o.is_tick = command_i;
    op_o.data    = rx_byte_i;
    op_o.zeros   = zero_count(rx_byte_i);
  end

endmodule

FILE: hdl/cnb_fifo.sv
module cnb_fifo #(
  parameter int unsigned Depth = cnb_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cnb_pkg::op_t        push_op_i,
  input  logic                pop_i,
  output cnb_pkg::op_t        pop_op_o,
  output cnb_pkg::fifo_stat_t stat_o
);
  import cnb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign pop_op_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: hdl/cnb_back.sv
module cnb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cnb_pkg::op_t        op_i,
  input  cnb_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                line_level_o,
  output logic                busy_res_o,
  output logic                command_done_o
);
  import cnb_pkg::*;

  logic [2:0]  parse_q, parse_d;
  logic [7:0]  frame_q [5];
  logic [7:0]  frame_d [5];
  logic [11:0] shift_q, shift_d;
  logic [3:0]  bits_q, bits_d;
  logic [2:0]  sent_q, sent_d;
  logic        line_q, line_d;
  logic        done_d;
  logic        take;
  logic [2:0]  slot;
  logic [8:0]  data9;
  logic        load;

  logic out_valid_q, out_busy_q, out_done_q;

  assign take  = !out_valid_q || !out_stall_i;
  assign pop_o = take && !stat_i.empty;
  assign slot  = parse_q - PosAddr;

  always_comb begin
    parse_d = parse_q;
    frame_d = frame_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    sent_d  = sent_q;
    line_d  = line_q;
    done_d  = 1'b0;
    data9   = '0;
    load    = 1'b0;
    if (pop_o) begin
      if (op_i.is_tick) begin
        if (bits_q != '0) begin
          line_d  = shift_q[0];
          bits_d  = bits_q - 1'b1;
          shift_d = {1'b0, shift_q[11:1]};
        end
        if (bits_d == '0) begin
          if (sent_q == '0) begin
            data9  = AddrFlag | {1'b0, frame_q[0]};
            load   = 1'b1;
            sent_d = 3'd1;
          end else if (sent_q < FrameWords) begin
            data9  = {1'b0, frame_q[sent_q]};
            load   = 1'b1;
            sent_d = sent_q + 1'b1;
          end
        end
        if (load) begin
          shift_d = StopBits | {2'b00, data9, 1'b0};
          bits_d  = WordBits;
        end
      end else begin
        unique case (parse_q)
          PosMagic: begin
            if (op_i.data == MagicByte) begin
              parse_d = PosCmd;
            end
          end
          PosCmd: begin
            if (op_i.data == CmdSet) begin
              frame_d[4] = '0;
              parse_d    = PosAddr;
            end else if (op_i.data == CmdLoad) begin
              frame_d[4] = LoadFlag;
              parse_d    = PosAddr;
            end else begin
              parse_d = PosMagic;
            end
          end
          PosAddr: begin
            frame_d[0] = op_i.data;
            parse_d    = PosRed;
          end
          PosRed, PosGreen, PosBlue: begin
            frame_d[slot] = op_i.data;
            frame_d[4] = frame_q[4] + {4'b0000, op_i.zeros};
            if (parse_q == PosBlue) begin
              parse_d = PosMagic;
              sent_d  = '0;
              done_d  = 1'b1;
            end else begin
              parse_d = parse_q + 1'b1;
            end
          end
          default: begin
            parse_d = PosMagic;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q     <= PosMagic;
      frame_q     <= '{default: '0};
      shift_q     <= '0;
      bits_q      <= '0;
      sent_q      <= FrameWords;
      line_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      parse_q <= parse_d;
      frame_q <= frame_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      sent_q  <= sent_d;
      line_q  <= line_d;
      if (take) begin
        out_valid_q <= !stat_i.empty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_busy_q <= (bits_d != '0) || (sent_d < FrameWords);
      out_done_q <= done_d;
    end
  end

  // line state only moves on a pop, so it always matches the held result
  assign out_valid_o    = out_valid_q;
  assign line_level_o   = line_q;
  assign busy_res_o     = out_busy_q;
  assign command_done_o = out_done_q;

endmodule

FILE: hdl/command_to_nine_bit_serial_bridge.sv
// Flow: the queue takes the item at the input transfer, the back end executes it and
// registers the result in its output register, where a stall at the output holds it.
// Throughput: one item per cycle; the back end takes one queued item per cycle while
// its output register is free or being taken. The FifoDepth-entry queue absorbs stall.
// Reset: asynchronous; parser at the magic byte, frame bytes zero, transmitter idle
// with the line high, queue and output empty.
module command_to_nine_bit_serial_bridge #(
  parameter int unsigned FifoDepth = cnb_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       line_level_o,
  output logic       busy_res_o,
  output logic       command_done_o
);
  import cnb_pkg::*;

  fifo_stat_t stat;
  op_t        push_op;
  op_t        pop_op;
  logic       push;
  logic       pop;

  cnb_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .rx_byte_i  (rx_byte_i),
    .stat_i     (stat),
    .push_o     (push),
    .op_o       (push_op)
  );

  cnb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .pop_op_o  (pop_op),
    .stat_o    (stat)
  );

  cnb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (pop_op),
    .stat_i         (stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_level_o   (line_level_o),
    .busy_res_o     (busy_res_o),
    .command_done_o (command_done_o)
  );

endmodule

FILE: hdl/cnb_checker.sv
module cnb_checker #(
  parameter int unsigned FifoDepth = cnb_pkg::FifoDepthDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       line_level_o,
  input logic       busy_res_o,
  input logic       command_done_o
);

  localparam int unsigned CntW = $clog2(FifoDepth + 2) + 1;

  logic [CntW-1:0] pend_q;
  logic            in_xfer;
  logic            out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // transfers taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + CntW'(in_xfer) - CntW'(out_xfer);
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without a pending transfer");

  a_accept_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> !in_stall_o)
    else $error("input stalled with nothing in flight");

  a_done_implies_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_done_o |-> busy_res_o)
    else $error("completed command without a busy transmitter");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_level_o)
      && $stable(busy_res_o) && $stable(command_done_o))
    else $error("stalled result changed");

endmodule

bind command_to_nine_bit_serial_bridge cnb_checker #(
  .FifoDepth (FifoDepth)
) u_cnb_checker (.*);

FILE: tb/command_to_nine_bit_serial_bridge_tb.sv
module command_to_nine_bit_serial_bridge_tb;
  import cnb_pkg::*;

  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

  localparam int IdlePct      = 13;
  localparam int RandomItems  = 1950;
  localparam int CalmFirst    = 700;
  localparam int CalmLast     = 1000;
  localparam int FrameTicks   = 61;
  localparam int DrainCycles  = 8;
  localparam int CycleLimit   = 200000;
  localparam int MaxReports   = 100;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic done;
  } serial_res_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       command_i   = KindByte;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       line_level_o;
  logic       busy_res_o;
  logic       command_done_o;

  command_to_nine_bit_serial_bridge DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_level_o   (line_level_o),
    .busy_res_o     (busy_res_o),
    .command_done_o (command_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // predicted bridge state
  logic [2:0]  parse_pos;
  logic [7:0]  frame [5];
  logic [11:0] tx_word;
  logic [3:0]  tx_left;
  logic [2:0]  tx_sent;
  logic        tx_line;

  serial_res_t expected_levels [$];
  serial_res_t got_res;
  serial_res_t want_res;
  int          errors      = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;
  bit          calm        = 1'b0;

  function automatic void clear_bridge_state();
    parse_pos = PosMagic;
    for (int i = 0; i < 5; i++) frame[i] = 8'h00;
    tx_word = '0;
    tx_left = '0;
    tx_sent = FrameWords;
    tx_line = 1'b1;
  endfunction

  function automatic logic [3:0] cleared_bits(logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) if (!v[i]) n = n + 4'd1;
    return n;
  endfunction

  function automatic void load_shift(logic [8:0] data9);
    tx_word = StopBits | {2'b00, data9, 1'b0};
    tx_left = WordBits;
  endfunction

  function automatic void shift_tick();
    if (tx_left != 0) begin
      tx_line = tx_word[0];
      tx_left = tx_left - 4'd1;
      tx_word = tx_word >> 1;
    end
    if (tx_left == 0) begin
      if (tx_sent == 3'd0) begin
        load_shift(AddrFlag | {1'b0, frame[0]});
        tx_sent = 3'd1;
      end else if (tx_sent < FrameWords) begin
        load_shift({1'b0, frame[tx_sent]});
        tx_sent = tx_sent + 3'd1;
      end
    end
  endfunction

  function automatic logic parse_byte(logic [7:0] b);
    logic [2:0] slot;
    logic       done;
    done = 1'b0;
    case (parse_pos)
      PosMagic: begin
        if (b == MagicByte) parse_pos = PosCmd;
      end
      PosCmd: begin
        if (b == CmdSet) begin
          frame[4]  = 8'h00;
          parse_pos = PosAddr;
        end else if (b == CmdLoad) begin
          frame[4]  = LoadFlag;
          parse_pos = PosAddr;
        end else begin
          // the offending byte is not reused as a magic byte
          parse_pos = PosMagic;
        end
      end
      PosAddr, PosRed, PosGreen, PosBlue: begin
        slot        = parse_pos - PosAddr;
        frame[slot] = b;
        if (slot != 0) frame[4] = frame[4] + {4'h0, cleared_bits(b)};
        if (parse_pos == PosBlue) begin
          parse_pos = PosMagic;
          tx_sent   = 3'd0;
          done      = 1'b1;
        end else begin
          parse_pos = parse_pos + 3'd1;
        end
      end
      default: parse_pos = PosMagic;
    endcase
    return done;
  endfunction

  function automatic serial_res_t predict_serial(logic kind, logic [7:0] b);
    serial_res_t r;
    r.done = 1'b0;
    if (kind == KindTick) shift_tick();
    else r.done = parse_byte(b);
    r.line_level = tx_line;
    r.busy       = (tx_left != 0) || (tx_sent < FrameWords);
    return r;
  endfunction

  // one input transfer; called at a rising edge, returns at the accepting edge
  task automatic send_item(logic kind, logic [7:0] b);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= kind;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    expected_levels.push_back(predict_serial(kind, b));
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(KindByte, b);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KindTick, 8'($urandom_range(255)));
  endtask

  // full command; tick_pct sprinkles bit ticks between the bytes
  task automatic send_command(logic [7:0] op, logic [7:0] addr, logic [7:0] red,
                              logic [7:0] green, logic [7:0] blue, int tick_pct);
    logic [7:0] seq [6];
    seq = '{MagicByte, op, addr, red, green, blue};
    foreach (seq[i]) begin
      if ($urandom_range(99) < tick_pct) send_ticks($urandom_range(1, 3));
      send_byte(seq[i]);
    end
  endtask

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s expected %0b got %0b", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res = '{line_level_o, busy_res_o, command_done_o};
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result, expected none got %b", $time, got_res);
      end else begin
        want_res = expected_levels.pop_front();
        check_field("line_level", want_res.line_level, got_res.line_level);
        check_field("busy_res", want_res.busy, got_res.busy);
        check_field("command_done", want_res.done, got_res.done);
      end
    end
  end

  task automatic test_idle_line();
    send_ticks(2);
  endtask

  task automatic test_protocol_errors();
    send_byte(8'h41);
    send_byte(MagicByte);
    send_byte(8'h58);
    // a magic byte right after a magic is a bad command byte, so the set after it is dropped
    send_byte(MagicByte);
    send_byte(MagicByte);
    send_byte(CmdSet);
  endtask

  task automatic test_set_command();
    send_command(CmdSet, 8'hFF, 8'h00, 8'hFF, 8'h00, 0);
    send_ticks(5);
  endtask

  task automatic test_load_mid_frame();
    // arrives while the set frame is still on the line
    send_command(CmdLoad, 8'h00, 8'hFF, 8'h00, 8'hFF, 0);
  endtask

  task automatic test_random_traffic();
    int         first;
    int         pick;
    logic [7:0] op;
    first = items_sent;
    while (items_sent < first + RandomItems) begin
      calm = (items_sent - first >= CalmFirst) && (items_sent - first < CalmLast);
      pick = $urandom_range(99);
      op   = $urandom_range(1) ? CmdSet : CmdLoad;
      if (pick < 70) begin
        send_command(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)), 25);
        if ($urandom_range(3) == 0) send_ticks($urandom_range(FrameTicks, FrameTicks + 14));
        else send_ticks($urandom_range(0, 20));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        send_byte(MagicByte);
        if ($urandom_range(1)) begin
          send_byte(8'($urandom_range(255)));
        end else begin
          send_byte(op);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
        end
        send_ticks($urandom_range(0, 12));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin
    clear_bridge_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_line();
    test_protocol_errors();
    test_set_command();
    test_load_mid_frame();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: command_to_nine_bit_serial_bridge.f
hdl/cnb_pkg.sv
hdl/cnb_front.sv
hdl/cnb_fifo.sv
hdl/cnb_back.sv
hdl/command_to_nine_bit_serial_bridge.sv
hdl/cnb_checker.sv
tb/command_to_nine_bit_serial_bridge_tb.sv
